// File: sv/spl_pkg.sv
// Package for the spool priority list: sizes, codes and payload structs.
// Used by spl_cell and spool_priority_list_unit; depends on nothing else.
`timescale 1ns / 1ps

package spl_pkg;

  // Sizes of the list and of the stored tag.
  localparam int LIST_DEPTH = 32;
  localparam int TAG_BITS   = 16;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  // Sequence characters further apart than this compare in inverted order.
  localparam int WRAP_SPAN = 10;

  // Reset value of the grade limit register.
  localparam logic [7:0] MAX_GRADE_RESET = 8'd127;

  // Operation codes.
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;
  localparam logic [1:0] OP_PROBE  = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_REJECTED = 2'd3;

  // One stored list entry.
  typedef struct packed {
    logic [7:0]          grade;
    logic [7:0]          seq_first;
    logic [23:0]         seq_rest;
    logic [TAG_BITS-1:0] tag;
  } spl_entry_t;

  // Request payload.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  grade;
    logic [7:0]  seq_first;
    logic [23:0] seq_rest;
    logic [15:0] tag;
  } spl_req_t;

  // Response payload.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_grade;
    logic [7:0]  out_seq_first;
    logic [23:0] out_seq_rest;
    logic [15:0] out_tag;
    logic [5:0]  entry_count;
  } spl_rsp_t;

  // Shift commands broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic pop;
  } spl_ctrl_t;

endpackage

// File: sv/spl_cell.sv
// One cell of the sorted list: holds an entry, ranks it against a new key
// and shifts toward either neighbor. Depends on spl_pkg.
`timescale 1ns / 1ps

module spl_cell (
  input  logic               clk,
  input  spl_pkg::spl_ctrl_t ctrl,
  input  spl_pkg::spl_entry_t new_entry,
  input  spl_pkg::spl_entry_t below_entry,
  input  spl_pkg::spl_entry_t above_entry,
  input  logic               occupied,
  input  logic               blocked_above,
  input  logic               blocked_below,
  output logic               blocked,
  output spl_pkg::spl_entry_t entry
);

  logic              outranks;
  logic signed [8:0] seq_diff;

  // True when the new entry is strictly more urgent than the held one.
  always_comb begin
    seq_diff = $signed({1'b0, entry.seq_first}) - $signed({1'b0, new_entry.seq_first});
    if (new_entry.grade != entry.grade) begin
      outranks = new_entry.grade < entry.grade;
    end else if (seq_diff != 9'sd0) begin
      if (seq_diff < -9'(spl_pkg::WRAP_SPAN) || seq_diff > 9'(spl_pkg::WRAP_SPAN)) begin
        outranks = seq_diff < 9'sd0;
      end else begin
        outranks = seq_diff > 9'sd0;
      end
    end else begin
      outranks = new_entry.seq_rest < entry.seq_rest;
    end
  end

  // A held entry the new one does not outrank stops the shift here and below.
  assign blocked = blocked_above | (occupied & ~outranks);

  // Insert shifts up from the insertion point; pop shifts everything down.
  always_ff @(posedge clk) begin
    if (ctrl.ins && !blocked) begin
      entry <= blocked_below ? new_entry : below_entry;
    end else if (ctrl.pop) begin
      entry <= above_entry;
    end
  end

endmodule

// File: sv/spool_priority_list_unit.sv
// Top level of the spool priority list: a row of spl_cell instances, the
// fill count, the grade limit register and the response register.
// Depends on spl_pkg and spl_cell.
//
//   channel  direction  payload     handshake
//   req      in         spl_req_t   req_valid / req_stall
//   rsp      out        spl_rsp_t   rsp_valid / rsp_stall
//   cfg      in         8-bit data  cfg_wr_en, no wait
//
// One request is taken per cycle while req_stall is low, and its response
// appears in the response register in the cycle after it is taken. The insert
// rank is decided by all cells at once and rippled down the row of cells.
// Reset clears the fill count, the response valid and sets max_grade to 127;
// the cells themselves are not cleared. A request is stalled only while a
// response is held and the response side stalls.
`timescale 1ns / 1ps

module spool_priority_list_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  spl_pkg::spl_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output spl_pkg::spl_rsp_t rsp,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data
);

  localparam int D = spl_pkg::LIST_DEPTH;
  localparam int W = spl_pkg::CNT_W;

  logic [7:0]          max_grade;
  logic [W-1:0]        count;
  logic [W-1:0]        count_next;
  spl_pkg::spl_rsp_t   rsp_next;
  spl_pkg::spl_ctrl_t  ctrl;
  spl_pkg::spl_entry_t new_entry;
  spl_pkg::spl_entry_t cell_entry [D];
  logic [D-1:0]        cell_blocked;
  logic [D-1:0]        occupied;
  logic                accept;
  logic                grade_ok;
  logic                full;
  logic                empty;

  // Transfer handshake: the response register frees as it is taken.
  assign req_stall = rsp_valid & rsp_stall;
  assign accept    = req_valid & ~req_stall;

  assign new_entry.grade     = req.grade;
  assign new_entry.seq_first = req.seq_first;
  assign new_entry.seq_rest  = req.seq_rest;
  assign new_entry.tag       = spl_pkg::TAG_BITS'(req.tag);

  assign grade_ok = req.grade <= max_grade;
  assign full     = count == W'(D);
  assign empty    = count == '0;

  assign ctrl.ins = accept && req.opcode == spl_pkg::OP_INSERT && grade_ok && !full;
  assign ctrl.pop = accept && req.opcode == spl_pkg::OP_POP && !empty;

  // Row of cells; blocked ripples from the tail toward the head.
  for (genvar j = 0; j < D; j++) begin : g_cell
    assign occupied[j] = W'(j) < count;
    spl_cell u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .new_entry     (new_entry),
      .below_entry   ((j == 0) ? new_entry : cell_entry[(j == 0) ? 0 : j - 1]),
      .above_entry   ((j == D - 1) ? cell_entry[j] : cell_entry[(j == D - 1) ? j : j + 1]),
      .occupied      (occupied[j]),
      .blocked_above ((j == D - 1) ? 1'b0 : cell_blocked[(j == D - 1) ? j : j + 1]),
      .blocked_below ((j == 0) ? 1'b1 : cell_blocked[(j == 0) ? 0 : j - 1]),
      .blocked       (cell_blocked[j]),
      .entry         (cell_entry[j])
    );
  end

  // Next count and response for the accepted request.
  always_comb begin
    count_next = count;
    rsp_next   = '0;
    case (req.opcode)
      spl_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      spl_pkg::OP_INSERT: begin
        if (!grade_ok) begin
          rsp_next.status = spl_pkg::ST_REJECTED;
        end else if (full) begin
          rsp_next.status = spl_pkg::ST_FULL;
        end else begin
          count_next = count + W'(1);
        end
      end
      spl_pkg::OP_POP: begin
        if (empty) begin
          rsp_next.status = spl_pkg::ST_EMPTY;
        end else begin
          count_next             = count - W'(1);
          rsp_next.out_grade     = cell_entry[0].grade;
          rsp_next.out_seq_first = cell_entry[0].seq_first;
          rsp_next.out_seq_rest  = cell_entry[0].seq_rest;
          rsp_next.out_tag       = 16'(cell_entry[0].tag);
        end
      end
      spl_pkg::OP_PROBE: begin
        rsp_next.status = grade_ok ? spl_pkg::ST_OK : spl_pkg::ST_REJECTED;
      end
      default: begin
        count_next = count;
      end
    endcase
    rsp_next.entry_count = 6'(count_next);
  end

  // Control registers: count, grade limit, response valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      max_grade <= spl_pkg::MAX_GRADE_RESET;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_grade <= cfg_wr_data;
      end
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Response payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule
